/* rtl/rcs_pkg.sv */
package rcs_pkg;

	// field widths
	localparam int LEN_W      = 11;
	localparam int SEQ_W      = 31;
	localparam int WORD_W     = 32;
	localparam int PORT_TAG_W = 16;

	// packet layout
	localparam int HEADER_BYTES         = 8;
	localparam int PORT_TAG_BYTES       = 2;
	localparam int MAX_PACKET_BYTES_DEF = 1400;

	// stream payload widths (tdata packed, padded to whole bytes)
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 128;
	localparam int STATUS_W    = 2;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIENT_MODE = 1'b0,
		REG_PORT_TAG    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_TX = 1'b0,
		KIND_RX = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SENT     = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_ACCEPTED = 2'd2,
		ST_STALE    = 2'd3
	} status_t;

endpackage

/* rtl/reliable_channel_sequencer.sv */
// Sequencing core of an even/odd reliable datagram channel. Each request on the
// s_axis side is either a transmit request (tuser = 0) or the two header words
// of a received packet (tuser = 1); each request gives exactly one result on the
// m_axis side, whose tuser carries the status (sent, overflow abort, accepted,
// stale drop). A transmit request decides whether the reliable slot is sent or
// resent, moves a pending message into an empty slot (message_taken tells the
// host to clear its buffer), builds both header words and reports whether the
// unreliable part still fits into MAX_PACKET_BYTES. A receive request drops
// stale sequences, reports how many packets were skipped, releases an
// acknowledged reliable slot and toggles the incoming parity. Sequence counters
// wrap at 31 bits. Timing: the decision for one request is made in the cycle it
// is accepted and lands in the result register, valid in the cycle after; a new
// request is taken every cycle while the output is free or being read, and the
// channel state registers, the only loop, update on acceptance. Result fields
// that do not apply are zero. Configuration (client_mode, port_tag) must be
// written via cfg_we/cfg_index/cfg_wdata only while idle; the block won't check.
module reliable_channel_sequencer #(
	parameter int MAX_PACKET_BYTES = rcs_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [rcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcs_pkg::CFG_DATA_W-1:0]      cfg_wdata,

	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [10:0] pending_length, [11] pending_overflow, [22:12] unreliable_length,
	// [54:23] rx_word_seq, [86:55] rx_word_ack, [87] zero
	input  logic [rcs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [0] kind
	input  logic                                s_axis_tuser,

	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] tx_word_seq, [63:32] tx_word_ack, [64] send_port_tag,
	// [80:65] port_tag_out, [91:81] reliable_bytes, [92] unreliable_included,
	// [93] message_taken, [124:94] dropped_count, [125] reliable_received,
	// [127:126] zero
	output logic [rcs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// [1:0] status
	output logic [rcs_pkg::STATUS_W-1:0]        m_axis_tuser
);

	import rcs_pkg::*;

	// wide enough for header + tag + reliable bytes + unreliable bytes and the limit
	localparam int SPACE_W = $clog2(MAX_PACKET_BYTES + 2 * (2 ** LEN_W) +
		HEADER_BYTES + PORT_TAG_BYTES + 1);

	// configuration registers
	logic                  client_mode_q;
	logic [PORT_TAG_W-1:0] port_tag_q;

	// channel state
	logic [SEQ_W-1:0] out_seq_q;
	logic [SEQ_W-1:0] in_seq_q;
	logic [SEQ_W-1:0] in_acked_seq_q;
	logic             in_acked_parity_q;
	logic             in_reliable_parity_q;
	logic             out_reliable_parity_q;
	logic [SEQ_W-1:0] last_reliable_sent_seq_q;
	logic [LEN_W-1:0] reliable_slot_len_q;

	// result register
	logic                   res_valid_q;
	logic [OUT_TDATA_W-1:0] res_data_q;
	logic [STATUS_W-1:0]    res_status_q;

	// request fields
	logic [LEN_W-1:0]  pending_length;
	logic              pending_overflow;
	logic [LEN_W-1:0]  unreliable_length;
	logic [WORD_W-1:0] rx_word_seq;
	logic [WORD_W-1:0] rx_word_ack;

	logic accept;

	// transmit decision
	logic               slot_empty;
	logic               take_msg;
	logic               resend;
	logic               send_rel;
	logic [LEN_W-1:0]   slot_len_tx;
	logic [SEQ_W-1:0]   out_seq_next;
	logic [SPACE_W-1:0] used_bytes;
	logic [SPACE_W-1:0] total_bytes;
	logic               fits;

	// receive decision
	logic [SEQ_W-1:0] rx_seq;
	logic [SEQ_W-1:0] rx_ack;
	logic             rx_rel_msg;
	logic             rx_rel_ack;
	logic             fresh;
	logic [SEQ_W-1:0] dropped;

	// next result
	logic [OUT_TDATA_W-1:0] res_data_d;
	status_t                res_status_d;

	assign pending_length    = s_axis_tdata[10:0];
	assign pending_overflow  = s_axis_tdata[11];
	assign unreliable_length = s_axis_tdata[22:12];
	assign rx_word_seq       = s_axis_tdata[54:23];
	assign rx_word_ack       = s_axis_tdata[86:55];

	// output register frees as soon as its result is taken
	assign s_axis_tready = !res_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_data_q;
	assign m_axis_tuser  = res_status_q;

	// transmit: resend on an ack of the other parity, or load a fresh message
	assign slot_empty   = (reliable_slot_len_q == '0);
	assign take_msg     = slot_empty && (pending_length != '0);
	assign resend       = (in_acked_seq_q > last_reliable_sent_seq_q) &&
		(in_acked_parity_q != out_reliable_parity_q);
	assign send_rel     = resend || take_msg;
	assign slot_len_tx  = take_msg ? pending_length : reliable_slot_len_q;
	assign out_seq_next = out_seq_q + SEQ_W'(1);

	// space check: header, optional port tag, reliable bytes, then unreliable
	assign used_bytes  = SPACE_W'(HEADER_BYTES) +
		(client_mode_q ? SPACE_W'(PORT_TAG_BYTES) : SPACE_W'(0)) +
		(send_rel ? SPACE_W'(slot_len_tx) : SPACE_W'(0));
	assign total_bytes = used_bytes + SPACE_W'(unreliable_length);
	assign fits        = (total_bytes <= SPACE_W'(MAX_PACKET_BYTES));

	// receive: anything not newer than the last accepted sequence is stale
	assign rx_seq     = rx_word_seq[SEQ_W-1:0];
	assign rx_ack     = rx_word_ack[SEQ_W-1:0];
	assign rx_rel_msg = rx_word_seq[WORD_W-1];
	assign rx_rel_ack = rx_word_ack[WORD_W-1];
	assign fresh      = (rx_seq > in_seq_q);
	assign dropped    = rx_seq - in_seq_q - SEQ_W'(1);

	always_comb begin
		res_data_d   = '0;
		res_status_d = ST_SENT;
		if (s_axis_tuser == KIND_TX) begin
			if (pending_overflow) begin
				res_status_d = ST_OVERFLOW;
			end else begin
				res_status_d       = ST_SENT;
				res_data_d[31:0]   = {send_rel, out_seq_q};
				res_data_d[63:32]  = {in_reliable_parity_q, in_seq_q};
				res_data_d[64]     = client_mode_q;
				res_data_d[80:65]  = client_mode_q ? port_tag_q : '0;
				res_data_d[91:81]  = send_rel ? slot_len_tx : '0;
				res_data_d[92]     = fits;
				res_data_d[93]     = take_msg;
			end
		end else begin
			if (fresh) begin
				res_status_d       = ST_ACCEPTED;
				res_data_d[124:94] = dropped;
				res_data_d[125]    = rx_rel_msg;
			end else begin
				res_status_d = ST_STALE;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_mode_q <= 1'b0;
			port_tag_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CLIENT_MODE: client_mode_q <= cfg_wdata[0];
				REG_PORT_TAG:    port_tag_q    <= cfg_wdata[PORT_TAG_W-1:0];
				default: ;
			endcase
		end
	end

	// channel state, updated in the cycle a request is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_seq_q                <= SEQ_W'(1);
			in_seq_q                 <= '0;
			in_acked_seq_q           <= '0;
			in_acked_parity_q        <= 1'b0;
			in_reliable_parity_q     <= 1'b0;
			out_reliable_parity_q    <= 1'b0;
			last_reliable_sent_seq_q <= '0;
			reliable_slot_len_q      <= '0;
		end else if (accept) begin
			if (s_axis_tuser == KIND_TX) begin
				if (!pending_overflow) begin
					out_seq_q <= out_seq_next;
					if (take_msg) begin
						reliable_slot_len_q   <= pending_length;
						out_reliable_parity_q <= !out_reliable_parity_q;
					end
					if (send_rel) begin
						last_reliable_sent_seq_q <= out_seq_next;
					end
				end
			end else if (fresh) begin
				// the peer saw our current parity: slot is released
				if (rx_rel_ack == out_reliable_parity_q) begin
					reliable_slot_len_q <= '0;
				end
				in_seq_q          <= rx_seq;
				in_acked_seq_q    <= rx_ack;
				in_acked_parity_q <= rx_rel_ack;
				if (rx_rel_msg) begin
					in_reliable_parity_q <= !in_reliable_parity_q;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q   <= res_data_d;
			res_status_q <= res_status_d;
		end
	end

endmodule

/* tb/tb_reliable_channel_sequencer.sv */
module tb_reliable_channel_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import rcs_pkg::*;

	localparam int          PKT_MAX    = MAX_PACKET_BYTES_DEF;
	localparam int          LEN_MAX    = 1400;
	localparam logic [30:0] SEQ_TOP    = 31'h7FFF_FFFF;
	localparam int unsigned CYCLE_CAP  = 300000;
	localparam int unsigned LONG_HOLD  = 400;

	// one request as the host offers it
	typedef struct packed {
		kind_t       kind;
		logic [10:0] pend_len;
		logic        pend_ovf;
		logic [10:0] unrel_len;
		logic [31:0] rx_seq_word;
		logic [31:0] rx_ack_word;
	} chan_req_t;

	// one header decision as the block reports it
	typedef struct packed {
		status_t     status;
		logic [31:0] seq_word;
		logic [31:0] ack_word;
		logic        tag_flag;
		logic [15:0] tag_value;
		logic [10:0] rel_bytes;
		logic        unrel_fits;
		logic        msg_taken;
		logic [30:0] skipped;
		logic        rel_in;
	} chan_outcome_t;

	// tracks the channel state and the header decisions still owed by the block
	class chan_seq_checker;
		logic        client_mode;
		logic [15:0] port_tag;
		logic [30:0] next_tx_seq;
		logic [30:0] last_rx_seq;
		logic [30:0] peer_ack_seq;
		logic        peer_ack_parity;
		logic        rx_parity;
		logic        tx_parity;
		logic [30:0] resend_mark;
		logic [10:0] slot_bytes;
		chan_outcome_t outcomes_due[$];
		int unsigned errors;

		function new();
			client_mode     = 1'b0;
			port_tag        = '0;
			next_tx_seq     = 31'd1;
			last_rx_seq     = '0;
			peer_ack_seq    = '0;
			peer_ack_parity = 1'b0;
			rx_parity       = 1'b0;
			tx_parity       = 1'b0;
			resend_mark     = '0;
			slot_bytes      = '0;
			errors          = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [15:0] val);
			case (idx)
				REG_CLIENT_MODE: client_mode = val[0];
				REG_PORT_TAG:    port_tag = val;
				default:         ;
			endcase
		endfunction

		function int unsigned pending();
			return outcomes_due.size();
		endfunction

		// advance the channel state by one accepted request
		function void note_request(chan_req_t r);
			chan_outcome_t e;
			logic          send_rel;
			int            used;
			logic [30:0]   seq;
			e = '0;
			if (r.kind == KIND_TX) begin
				if (r.pend_ovf) begin
					e.status = ST_OVERFLOW;
				end else begin
					send_rel = (peer_ack_seq > resend_mark && peer_ack_parity != tx_parity) ||
					           (slot_bytes == 0 && r.pend_len != 0);
					if (slot_bytes == 0 && r.pend_len != 0) begin
						slot_bytes  = r.pend_len;
						tx_parity   = ~tx_parity;
						e.msg_taken = 1'b1;
					end
					e.status   = ST_SENT;
					e.seq_word = {send_rel, next_tx_seq};
					e.ack_word = {rx_parity, last_rx_seq};
					next_tx_seq = next_tx_seq + 31'd1;
					used = HEADER_BYTES + (client_mode ? PORT_TAG_BYTES : 0);
					if (send_rel) begin
						e.rel_bytes = slot_bytes;
						used        = used + int'(slot_bytes);
						resend_mark = next_tx_seq;
					end
					e.unrel_fits = (used <= PKT_MAX) && (PKT_MAX - used >= int'(r.unrel_len));
					e.tag_flag   = client_mode;
					e.tag_value  = client_mode ? port_tag : 16'h0;
				end
			end else begin
				seq = r.rx_seq_word[30:0];
				if (seq <= last_rx_seq) begin
					e.status = ST_STALE;
				end else begin
					e.status  = ST_ACCEPTED;
					e.skipped = seq - last_rx_seq - 31'd1;
					e.rel_in  = r.rx_seq_word[31];
					if (r.rx_ack_word[31] == tx_parity)
						slot_bytes = '0;
					last_rx_seq     = seq;
					peer_ack_seq    = r.rx_ack_word[30:0];
					peer_ack_parity = r.rx_ack_word[31];
					if (r.rx_seq_word[31])
						rx_parity = ~rx_parity;
				end
			end
			outcomes_due.push_back(e);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d, logic [STATUS_W-1:0] u);
			chan_outcome_t e;
			if (outcomes_due.size() == 0) begin
				$error("result with no request outstanding: tdata 0x%0h", d);
				errors++;
				return;
			end
			e = outcomes_due.pop_front();
			compare("status", 32'(e.status), 32'(u));
			compare("tx_word_seq", e.seq_word, d[31:0]);
			compare("tx_word_ack", e.ack_word, d[63:32]);
			compare("send_port_tag", 32'(e.tag_flag), 32'(d[64]));
			compare("port_tag_out", 32'(e.tag_value), 32'(d[80:65]));
			compare("reliable_bytes", 32'(e.rel_bytes), 32'(d[91:81]));
			compare("unreliable_included", 32'(e.unrel_fits), 32'(d[92]));
			compare("message_taken", 32'(e.msg_taken), 32'(d[93]));
			compare("dropped_count", 32'(e.skipped), 32'(d[124:94]));
			compare("reliable_received", 32'(e.rel_in), 32'(d[125]));
		endfunction
	endclass

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// block inputs, all known from time zero
	logic                   cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [10:0] pending_length, [11] pending_overflow, [22:12] unreliable_length,
	// [54:23] rx_word_seq, [86:55] rx_word_ack, [87] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	// [0] kind
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [31:0] tx_word_seq, [63:32] tx_word_ack, [64] send_port_tag,
	// [80:65] port_tag_out, [91:81] reliable_bytes, [92] unreliable_included,
	// [93] message_taken, [124:94] dropped_count, [125] reliable_received
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// [1:0] status
	logic [STATUS_W-1:0]    m_axis_tuser;

	reliable_channel_sequencer #(
		.MAX_PACKET_BYTES(PKT_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	chan_seq_checker sb;

	// idle rates in percent per cycle, changed between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// raised once by the main flow to start the long receiver hold-off
	bit          stall_pending = 1'b0;

	// request builders
	function automatic chan_req_t tx_req(int unsigned pend, bit ovf, int unsigned unrel);
		chan_req_t r;
		r           = '0;
		r.kind      = KIND_TX;
		r.pend_len  = 11'(pend);
		r.pend_ovf  = ovf;
		r.unrel_len = 11'(unrel);
		return r;
	endfunction

	function automatic chan_req_t rx_req(bit rel, logic [30:0] seq, bit apar, logic [30:0] ack);
		chan_req_t r;
		r             = '0;
		r.kind        = KIND_RX;
		r.rx_seq_word = {rel, seq};
		r.rx_ack_word = {apar, ack};
		return r;
	endfunction

	// random request, mostly shaped after the live channel state so that
	// sends, resends, acks and releases all keep happening
	function automatic chan_req_t make_request();
		chan_req_t   r;
		int unsigned pick;
		int          slot_after;
		int          room;
		int          u;
		logic [30:0] ack;
		pick = $urandom_range(99);
		if (pick < 55) begin
			r = tx_req(0, ($urandom_range(99) < 4), 0);
			case ($urandom_range(3))
				0:       r.pend_len = '0;
				1:       r.pend_len = 11'($urandom_range(LEN_MAX));
				2:       r.pend_len = 11'($urandom_range(40));
				default: r.pend_len = 11'($urandom_range(LEN_MAX, LEN_MAX - 20));
			endcase
			// aim the unreliable length at the fit boundary a quarter of the time
			slot_after = (sb.slot_bytes == 0) ? int'(r.pend_len) : int'(sb.slot_bytes);
			room = PKT_MAX - HEADER_BYTES - (sb.client_mode ? PORT_TAG_BYTES : 0) - slot_after;
			if (room < 0)
				room = 0;
			if ($urandom_range(3) == 0) begin
				u = room + int'($urandom_range(2)) - 1;
				if (u < 0)
					u = 0;
				if (u > LEN_MAX)
					u = LEN_MAX;
			end else begin
				u = int'($urandom_range(LEN_MAX));
			end
			r.unrel_len = 11'(u);
		end else if (pick < 90 && sb.last_rx_seq <= SEQ_TOP - 31'd3) begin
			// next packet from the peer, occasionally with a few lost
			case ($urandom_range(3))
				0:       ack = sb.resend_mark - 31'd1;
				1:       ack = sb.resend_mark;
				2:       ack = sb.resend_mark + 31'd1;
				default: ack = sb.next_tx_seq - 31'd1;
			endcase
			r = rx_req(1'($urandom_range(1)), sb.last_rx_seq + 31'($urandom_range(3, 1)),
			           ($urandom_range(99) < 60) ? sb.tx_parity : ~sb.tx_parity, ack);
		end else begin
			// stale or duplicated packet with a noisy ack word
			r = rx_req(1'($urandom_range(1)), 31'($urandom_range(sb.last_rx_seq)),
			           1'($urandom_range(1)), 31'($urandom()));
		end
		return r;
	endfunction

	// offer one request, with random idle cycles ahead of it; starts and ends
	// on a falling edge
	task automatic send_request(chan_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.kind;
		s_axis_tdata  <= {1'b0, r.rx_ack_word, r.rx_seq_word, r.unrel_len, r.pend_ovf,
		                  r.pend_len};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(r);
		@(negedge clk);
	endtask

	// register write while idle; returns with the write enable low
	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic run_phase(int unsigned n_items, int unsigned tx_gap, int unsigned rx_gap);
		send_idle_pct = tx_gap;
		recv_idle_pct = rx_gap;
		repeat (n_items)
			send_request(make_request());
	endtask

	// stop offering and wait for every owed result
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// receiver: random back-pressure, plus one long hold-off on demand
	initial begin : receiver
		int unsigned hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (stall_pending) begin
				hold          = LONG_HOLD;
				stall_pending = 1'b0;
			end
			if (hold != 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// run limit
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL reliable_channel_sequencer");
		$finish;
	end

	initial begin : main_flow
		sb = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// server mode; the tag must stay masked off
		write_reg(REG_CLIENT_MODE, 16'h0);
		write_reg(REG_PORT_TAG, 16'hFFFF);

		// directed part: header extremes, overflow abort, fit boundary,
		// stale and duplicate drops, resend, release and an empty-slot resend
		send_idle_pct = 20;
		recv_idle_pct = 30;
		send_request(tx_req(0, 0, 0));
		send_request(tx_req(LEN_MAX, 1, LEN_MAX));
		send_request(tx_req(LEN_MAX, 0, 0));
		send_request(tx_req(5, 0, LEN_MAX));
		send_request(tx_req(0, 0, 1392));
		send_request(tx_req(0, 0, 1393));
		send_request(rx_req(1, 31'd1, 0, 31'd0));
		send_request(rx_req(0, 31'd1, 0, 31'd0));
		send_request(rx_req(1, 31'd0, 1, 31'd0));
		send_request(rx_req(0, 31'd5, 0, 31'h100));
		send_request(tx_req(7, 0, 0));
		send_request(rx_req(0, 31'd6, 1, 31'h100));
		send_request(tx_req(1392, 0, 0));
		send_request(tx_req(0, 0, 1));
		send_request(rx_req(1, 31'd7, 0, SEQ_TOP));
		send_request(rx_req(0, 31'd8, 1, SEQ_TOP));
		send_request(tx_req(0, 0, 0));
		send_request(rx_req(1, 31'd20, 0, 31'd0));
		send_request(tx_req(600, 0, 600));
		send_request(rx_req(1, 31'd21, 1, 31'd30));
		drain();

		// client mode, sender idles less than the receiver
		write_reg(REG_CLIENT_MODE, 16'h1);
		write_reg(REG_PORT_TAG, 16'h0000);
		run_phase(500, 36, 62);
		drain();

		// all-ones tag, idle rates swapped
		write_reg(REG_PORT_TAG, 16'hFFFF);
		run_phase(500, 62, 36);
		drain();

		// back to server mode, no idling, long receiver hold-off up front
		write_reg(REG_CLIENT_MODE, 16'h0);
		write_reg(REG_PORT_TAG, 16'($urandom()));
		stall_pending = 1'b1;
		run_phase(500, 0, 0);
		drain();

		// client mode again; finish with large sequence jumps up to the top
		write_reg(REG_CLIENT_MODE, 16'h1);
		write_reg(REG_PORT_TAG, 16'($urandom()));
		run_phase(370, 0, 0);
		send_request(rx_req(1'($urandom_range(1)),
		                    sb.last_rx_seq + 31'($urandom_range(32'h4000_0000, 32'h2000_0000)),
		                    1'($urandom_range(1)), 31'($urandom())));
		run_phase(40, 0, 0);
		send_request(rx_req(1, SEQ_TOP, 1, SEQ_TOP));
		run_phase(40, 0, 0);
		drain();

		// let any stray result show up
		repeat (4) @(negedge clk);
		if (sb.errors == 0)
			$display("PASS reliable_channel_sequencer");
		else
			$display("FAIL reliable_channel_sequencer");
		$finish;
	end

endmodule

/* files.f */
rtl/rcs_pkg.sv
rtl/reliable_channel_sequencer.sv
tb/tb_reliable_channel_sequencer.sv
